// ----- hw/rtl/wbe_pkg.sv -----
package wbe_pkg;

  // Sizes of the id space and of the word store
  localparam int unsigned MaxIds     = 4096;
  localparam int unsigned StoreWords = 64;
  localparam int unsigned WordBits   = 64;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [12:0] MaxIdsW = 13'(MaxIds);

  // Register indexes of the configuration port
  localparam logic CfgDestBase  = 1'b0;
  localparam logic CfgDestCount = 1'b1;

  // Request modes as they arrive on the input
  typedef enum logic [2:0] {
    MODE_AND  = 3'd0,
    MODE_OR   = 3'd1,
    MODE_COPY = 3'd2,
    MODE_FIND = 3'd3,
    MODE_ZERO = 3'd4
  } mode_e;

  // Decoded operation handed to the back end
  typedef enum logic [2:0] {
    OP_AND,
    OP_OR,
    OP_COPY,
    OP_FIND,
    OP_ZERO,
    OP_NOP
  } op_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_FIND1,
    ST_FIND2
  } st_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] operand_base;
    logic [12:0] operand_count;
    logic [5:0]  word_number;
    logic [63:0] operand_word;
    logic [12:0] start_id;
  } in_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic        applied;
    logic [12:0] found_id;
  } res_t;

  // Classified request: word ops carry the merge mask, find carries its bounds
  typedef struct packed {
    op_e         op;
    logic [5:0]  word;       // word number, or first word of a find
    logic [63:0] opword;
    logic [63:0] mask;
    logic        apply;
    logic [12:0] cid;        // clamped find start
    logic [12:0] fend;       // end of the destination range
    logic [5:0]  last;       // last word of the destination range
    logic        fdone;      // find start already at or past the end
  } cmd_t;

  // Lowest set bit of a byte
  function automatic logic [2:0] low8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Lowest set bit of a word, byte groups first
  function automatic logic [5:0] low64(input logic [63:0] v);
    logic [7:0] g;
    logic [2:0] gi;
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      g[i] = |v[i*8 +: 8];
    end
    gi = low8(g);
    b  = v[{gi, 3'b000} +: 8];
    return {gi, low8(b)};
  endfunction

endpackage

// ----- hw/rtl/wbe_ram.sv -----
module wbe_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/wbe_front.sv -----
module wbe_front import wbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  in_t         item_i,
  output cmd_t        cmd_o
);

  logic [11:0] base_q, base_d;
  logic [12:0] count_q, count_d;

  // Configuration writes, saturated so that base + count stays within range
  always_comb begin
    logic [12:0] room;
    logic [12:0] val;
    base_d  = base_q;
    count_d = count_q;
    room    = '0;
    val     = '0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDestBase: begin
          room   = MaxIdsW - count_q;
          val    = {1'b0, cfg_data_i[11:0]};
          base_d = (val > room) ? room[11:0] : val[11:0];
        end
        CfgDestCount: begin
          room    = MaxIdsW - {1'b0, base_q};
          val     = cfg_data_i;
          count_d = (val > room) ? room : val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= MaxIdsW;
    end else begin
      base_q  <= base_d;
      count_q <= count_d;
    end
  end

  // Classify the request: intersection and masks, or find bounds
  always_comb begin
    logic [12:0] dend, lo, hi, hm1, cid, em1;
    logic [13:0] oend;         // operand end can run past 13 bits
    logic [5:0]  lw, hw;
    logic [63:0] m;
    dend = {1'b0, base_q} + count_q;
    oend = {2'b00, item_i.operand_base} + {1'b0, item_i.operand_count};
    lo   = (base_q > item_i.operand_base) ? {1'b0, base_q} : {1'b0, item_i.operand_base};
    hi   = ({1'b0, dend} < oend) ? dend : oend[12:0];
    hm1  = hi - 13'd1;
    lw   = lo[11:6];
    hw   = hm1[11:6];
    m    = AllOnes;
    if (item_i.word_number == lw) m = m & (AllOnes << lo[5:0]);
    if (item_i.word_number == hw) m = m & (AllOnes >> (~hm1[5:0]));
    cid  = (item_i.start_id < {1'b0, base_q}) ? {1'b0, base_q} : item_i.start_id;
    em1  = dend - 13'd1;

    cmd_o        = '0;
    cmd_o.opword = item_i.operand_word;
    cmd_o.mask   = m;
    cmd_o.apply  = (lo < hi) && (item_i.word_number >= lw) && (item_i.word_number <= hw);
    cmd_o.cid    = cid;
    cmd_o.fend   = dend;
    cmd_o.last   = em1[11:6];
    cmd_o.fdone  = (cid >= dend);
    cmd_o.word   = item_i.word_number;
    unique case (mode_e'(item_i.mode))
      MODE_AND:  cmd_o.op = OP_AND;
      MODE_OR:   cmd_o.op = OP_OR;
      MODE_COPY: cmd_o.op = OP_COPY;
      MODE_FIND: begin
        cmd_o.op   = OP_FIND;
        cmd_o.word = cid[11:6];
      end
      MODE_ZERO: cmd_o.op = OP_ZERO;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/wbe_cmdq.sv -----
module wbe_cmdq import wbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  // Two-entry queue between classification and execution
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) wp_d = ~wp_q;
    if (pop_i)  rp_d = ~rp_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= cmd_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = ent_q[rp_q];

endmodule

// ----- hw/rtl/wbe_back.sv -----
module wbe_back import wbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cq_empty_i,
  input  cmd_t cmd_i,
  output logic cq_pop_o,
  output res_t res_o,
  output logic empty_o,
  input  logic pop_i
);

  // Found id from word and bit, limited to the range end
  function automatic logic [12:0] found_at(input logic [5:0] w, input logic [5:0] b,
                                           input logic [12:0] e);
    logic [12:0] id;
    id = {1'b0, w, b};
    return (id < e) ? id : e;
  endfunction

  st_e         st_q, st_d;
  cmd_t        cur_q, cur_d;
  logic [63:0] val_q, val_d;   // word written since last clear
  logic [63:0] nz_q, nz_d;     // stored word is non-zero
  logic [63:0] fl_q, fl_d;     // candidate words for a find
  logic [5:0]  fidx_q, fidx_d;

  logic        re, we;
  logic [5:0]  raddr;
  logic [63:0] wdata, rdata;

  res_t        rb_q [2];
  logic        rwp_q, rrp_q;
  logic [1:0]  rcnt_q;
  logic        rpush, room;
  res_t        rnew;

  wbe_ram #(
    .Width(WordBits),
    .Depth(StoreWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cur_q.word),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign room = (rcnt_q != 2'd2);

  // Sequencer: read, then merge or search; zero and unused modes need no read
  always_comb begin
    logic [63:0] dv, rv, nv, w0;
    logic [5:0]  pick;
    st_d     = st_q;
    cur_d    = cur_q;
    val_d    = val_q;
    nz_d     = nz_q;
    fl_d     = fl_q;
    fidx_d   = fidx_q;
    cq_pop_o = 1'b0;
    re       = 1'b0;
    raddr    = cmd_i.word;
    we       = 1'b0;
    wdata    = '0;
    rpush    = 1'b0;
    rnew     = '0;
    dv       = val_q[cur_q.word] ? rdata : '0;
    rv       = '0;
    nv       = '0;
    w0       = dv & (AllOnes << cur_q.cid[5:0]);
    pick     = low64(fl_q);
    unique case (st_q)
      ST_IDLE: begin
        if (!cq_empty_i && room) begin
          cq_pop_o = 1'b1;
          cur_d    = cmd_i;
          unique case (cmd_i.op)
            OP_AND, OP_OR, OP_COPY: begin
              re   = 1'b1;
              st_d = ST_WORD;
            end
            OP_FIND: begin
              if (cmd_i.fdone) begin
                rpush         = 1'b1;
                rnew.found_id = cmd_i.fend;
              end else begin
                re = 1'b1;
                for (int j = 0; j < 64; j++) begin
                  fl_d[j] = nz_q[j] && (6'(j) > cmd_i.word) && (6'(j) <= cmd_i.last);
                end
                st_d = ST_FIND1;
              end
            end
            OP_ZERO: begin
              val_d = '0;
              nz_d  = '0;
              rpush = 1'b1;
            end
            default: rpush = 1'b1;
          endcase
        end
      end
      ST_WORD: begin
        priority case (cur_q.op)
          OP_AND:  rv = dv & cur_q.opword;
          OP_OR:   rv = dv | cur_q.opword;
          default: rv = cur_q.opword;
        endcase
        nv    = (dv & ~cur_q.mask) | (rv & cur_q.mask);
        rpush = 1'b1;
        if (cur_q.apply) begin
          we                 = 1'b1;
          wdata              = nv;
          val_d[cur_q.word]  = 1'b1;
          nz_d[cur_q.word]   = (nv != '0);
          rnew.result_word   = nv;
          rnew.applied       = 1'b1;
        end else begin
          rnew.result_word   = dv;
        end
        st_d = ST_IDLE;
      end
      ST_FIND1: begin
        if (w0 != '0) begin
          rpush         = 1'b1;
          rnew.found_id = found_at(cur_q.word, low64(w0), cur_q.fend);
          st_d          = ST_IDLE;
        end else if (fl_q == '0) begin
          rpush         = 1'b1;
          rnew.found_id = cur_q.fend;
          st_d          = ST_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = pick;
          fidx_d = pick;
          st_d   = ST_FIND2;
        end
      end
      ST_FIND2: begin
        rpush         = 1'b1;
        rnew.found_id = found_at(fidx_q, low64(rdata), cur_q.fend);
        st_d          = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      val_q <= '0;
      nz_q  <= '0;
    end else begin
      st_q  <= st_d;
      val_q <= val_d;
      nz_q  <= nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    fl_q   <= fl_d;
    fidx_q <= fidx_d;
  end

  // Two-entry result buffer towards the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwp_q  <= 1'b0;
      rrp_q  <= 1'b0;
      rcnt_q <= '0;
    end else begin
      if (rpush) rwp_q <= ~rwp_q;
      if (pop_i && !empty_o) rrp_q <= ~rrp_q;
      if (rpush && !(pop_i && !empty_o)) rcnt_q <= rcnt_q + 2'd1;
      if (!rpush && (pop_i && !empty_o)) rcnt_q <= rcnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpush) rb_q[rwp_q] <= rnew;
  end

  assign empty_o = (rcnt_q == 2'd0);
  assign res_o   = rb_q[rrp_q];

endmodule

// ----- hw/rtl/windowed_bitmask_engine.sv -----
// Windowed bitmask engine: a 64 x 64-bit mask store addressed by absolute word
// number, updated by AND/OR/COPY requests limited to the intersection of the
// destination and operand id ranges, searched by find-next-set and cleared by
// zero. Requests enter through a queue-style port (push/full) and one result
// per request leaves in order through empty/pop. A front end classifies each
// request into a two-entry queue; the back end executes it against a mask RAM
// with a write port and a registered read port. AND/OR/COPY read the word,
// then merge and write it back. Find-next returns the range end if its start
// is past the end; else it reads the start word and answers from it if that
// holds the answer or no later word is non-zero; else the per-word flags pick
// the next non-zero word, which a second read fetches. Zero and unused modes
// need no RAM read. Reset and zero clear per-word valid flags at once, so there
// is no clearing pass. The back end stalls once two results are buffered.
module windowed_bitmask_engine import wbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  in_t         item_i,
  output logic        empty,
  input  logic        pop,
  output res_t        res_o
);

  cmd_t cmd_in, cmd_head;
  logic cq_empty, cq_pop;

  wbe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .item_i    (item_i),
    .cmd_o     (cmd_in)
  );

  wbe_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .cmd_i  (cmd_in),
    .full_o (full),
    .pop_i  (cq_pop),
    .empty_o(cq_empty),
    .cmd_o  (cmd_head)
  );

  wbe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cq_empty_i(cq_empty),
    .cmd_i     (cmd_head),
    .cq_pop_o  (cq_pop),
    .res_o     (res_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

// ----- bench/windowed_bitmask_engine_tb.sv -----
`timescale 1ns / 100ps

module windowed_bitmask_engine_tb;
  import wbe_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  // Modes five to seven carry no operation
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we       = 1'b0;
  logic        cfg_idx      = 1'b0;
  logic [12:0] cfg_data     = '0;
  logic        push         = 1'b0;
  logic        full;
  in_t         request_item = '0;
  logic        empty;
  logic        pop          = 1'b0;
  res_t        res_out;

  // Predicted mask store and destination window
  logic [63:0] mask_mem [StoreWords];
  int unsigned dest_base;
  int unsigned dest_count;
  res_t        expected_results[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;

  windowed_bitmask_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .item_i     (request_item),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Smallest set id at or after start, clamped to the window
  function automatic int unsigned next_set_id(int unsigned start);
    int unsigned id_end, cid, wi, lastw, bitpos;
    logic [63:0] word;
    id_end = dest_base + dest_count;
    cid = (start < dest_base) ? dest_base : start;
    if (cid >= id_end) return id_end;
    wi    = cid / WordBits;
    lastw = (id_end - 1) / WordBits;
    word  = mask_mem[wi] & (AllOnes << (cid % WordBits));
    while (word == '0) begin
      wi++;
      if (wi > lastw) return id_end;
      word = mask_mem[wi];
    end
    bitpos = 0;
    for (int n = WordBits - 1; n >= 0; n--) begin
      if (word[n]) bitpos = n;
    end
    cid = wi * WordBits + bitpos;
    return (cid < id_end) ? cid : id_end;
  endfunction

  // Execute one request against the predicted store
  function automatic res_t apply_request(in_t it);
    res_t r;
    int unsigned dend, oend, lo, hi, w;
    logic [63:0] dv, m, rv;
    r = '0;
    w = it.word_number;
    case (it.mode)
      MODE_AND, MODE_OR, MODE_COPY: begin
        dend = dest_base + dest_count;
        oend = 32'(it.operand_base) + 32'(it.operand_count);
        lo   = (dest_base > 32'(it.operand_base)) ? dest_base : 32'(it.operand_base);
        hi   = (dend < oend) ? dend : oend;
        dv   = mask_mem[w];
        r.result_word = dv;
        if (lo < hi && w >= lo / WordBits && w <= (hi - 1) / WordBits) begin
          m = AllOnes;
          if (w == lo / WordBits) m &= AllOnes << (lo % WordBits);
          if (w == (hi - 1) / WordBits) m &= AllOnes >> (WordBits - 1 - (hi - 1) % WordBits);
          if (it.mode == MODE_AND) rv = dv & it.operand_word;
          else if (it.mode == MODE_OR) rv = dv | it.operand_word;
          else rv = it.operand_word;
          dv = (dv & ~m) | (rv & m);
          mask_mem[w]   = dv;
          r.result_word = dv;
          r.applied     = 1'b1;
        end
      end
      MODE_FIND: r.found_id = 13'(next_set_id(it.start_id));
      MODE_ZERO: foreach (mask_mem[i]) mask_mem[i] = '0;
      default: ;
    endcase
    return r;
  endfunction

  // Register write with the sum of base and count held to MaxIds
  function automatic void set_register(logic idx, logic [12:0] val);
    int unsigned b, c, room;
    if (idx == CfgDestBase) begin
      b    = val[11:0];
      room = MaxIds - dest_count;
      dest_base = (b > room) ? room : b;
    end else begin
      c    = val;
      room = (MaxIds > dest_base) ? MaxIds - dest_base : 0;
      dest_count = (c > room) ? room : c;
    end
  endfunction

  function automatic void report_failure(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  function automatic void check_result(res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      report_failure("unrequested result", '0, got.result_word);
      return;
    end
    want = expected_results.pop_front();
    if (got.result_word !== want.result_word)
      report_failure("result_word", want.result_word, got.result_word);
    if (got.applied !== want.applied)
      report_failure("applied", 64'(want.applied), 64'(got.applied));
    if (got.found_id !== want.found_id)
      report_failure("found_id", 64'(want.found_id), 64'(got.found_id));
  endfunction

  function automatic in_t make_request(logic [2:0] mode, int unsigned ob, int unsigned oc,
                                       int unsigned w, logic [63:0] ow, int unsigned sid);
    in_t r;
    r.mode          = mode;
    r.operand_base  = 12'(ob);
    r.operand_count = 13'(oc);
    r.word_number   = 6'(w);
    r.operand_word  = ow;
    r.start_id      = 13'(sid);
    return r;
  endfunction

  // Random request, mostly aimed into the current destination window
  function automatic in_t random_request();
    in_t r;
    int unsigned pick, lo, hi, dend, oend;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 20) r.mode = MODE_AND;
    else if (pick < 40) r.mode = MODE_OR;
    else if (pick < 58) r.mode = MODE_COPY;
    else if (pick < 90) r.mode = MODE_FIND;
    else if (pick < 94) r.mode = MODE_ZERO;
    else r.mode = 3'($urandom_range(ModeSpareLo, ModeSpareHi));

    case ($urandom_range(0, 3))
      0: begin
        r.operand_base  = 12'($urandom);
        r.operand_count = 13'($urandom);
      end
      1: begin
        r.operand_base  = '0;
        r.operand_count = 13'(MaxIds);
      end
      2: begin
        r.operand_base  = 12'(dest_base + $urandom_range(0, 127));
        r.operand_count = 13'($urandom_range(1, MaxIds));
      end
      default: begin
        r.operand_base  = 12'($urandom);
        r.operand_count = 13'($urandom_range(0, 320));
      end
    endcase

    dend = dest_base + dest_count;
    oend = 32'(r.operand_base) + 32'(r.operand_count);
    lo   = (dest_base > 32'(r.operand_base)) ? dest_base : 32'(r.operand_base);
    hi   = (dend < oend) ? dend : oend;
    if (lo < hi && $urandom_range(0, 3) != 0)
      r.word_number = 6'($urandom_range(lo / WordBits, (hi - 1) / WordBits));
    else
      r.word_number = 6'($urandom);

    case ($urandom_range(0, 5))
      0:       r.operand_word = AllOnes;
      1:       r.operand_word = '0;
      2, 3:    r.operand_word = 64'b1 << $urandom_range(0, WordBits - 1);
      default: r.operand_word = {$urandom, $urandom};
    endcase

    if (dest_count != 0 && $urandom_range(0, 9) < 7)
      r.start_id = 13'($urandom_range(dest_base, dest_base + dest_count - 1));
    else
      r.start_id = 13'($urandom);
    return r;
  endfunction

  task automatic pause_sender(int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one request and hold it until the block takes it; push stays high
  task automatic send_request(input in_t it);
    push         <= 1'b1;
    request_item <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    expected_results.push_back(apply_request(it));
    if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 14));
  endtask

  // Registers change only once every result has drained
  task automatic write_register(input logic idx, input logic [12:0] val);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    set_register(idx, val);
  endtask

  task automatic configure(int unsigned b, int unsigned c);
    write_register(CfgDestCount, '0);
    write_register(CfgDestBase, 13'(b));
    write_register(CfgDestCount, 13'(c));
  endtask

  task automatic test_word_ops();
    send_request(make_request(MODE_OR, 0, MaxIds, 0, AllOnes, 0));
    // head and tail masks of a range spanning two words
    send_request(make_request(MODE_OR, 70, 100, 1, AllOnes, 0));
    send_request(make_request(MODE_OR, 70, 100, 2, AllOnes, 0));
    send_request(make_request(MODE_COPY, 0, MaxIds, 1, 64'h0123_4567_89ab_cdef, 0));
    send_request(make_request(MODE_AND, 0, MaxIds, 0, 64'hf0f0_f0f0_0ff0_0ff0, 0));
    // empty operand range, then a word outside the intersection
    send_request(make_request(MODE_COPY, 0, 0, 0, '0, 0));
    send_request(make_request(MODE_COPY, 0, WordBits, 5, AllOnes, 0));
    // widest operand fields: only the last id of the window is touched
    send_request(make_request(MODE_COPY, 12'hfff, 13'h1fff, 63, AllOnes, 13'h1fff));
    send_request(make_request(MODE_AND, 0, MaxIds, 63, '0, 0));
  endtask

  task automatic test_find();
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 0));
    send_request(make_request(MODE_COPY, 0, MaxIds, 40, 64'b1 << 17, 0));
    // search skips empty words up to the single bit
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 2000));
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 2578));
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 13'h1fff));
  endtask

  task automatic test_zero_and_spare_modes();
    send_request(make_request(MODE_ZERO, 12'hfff, 13'h1fff, 63, AllOnes, 13'h1fff));
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 0));
    for (int m = ModeSpareLo; m <= ModeSpareHi; m++)
      send_request(make_request(3'(m), 12'hfff, 13'h1fff, 63, AllOnes, 13'h1fff));
  endtask

  task automatic test_register_limits();
    send_request(make_request(MODE_COPY, 0, MaxIds, 0, 64'b1, 0));
    // base cannot move while the count fills the id space
    write_register(CfgDestBase, 13'hfff);
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 0));
    write_register(CfgDestCount, 13'd100);
    write_register(CfgDestBase, 13'h1fff);
    send_request(make_request(MODE_OR, 0, MaxIds, 62, AllOnes, 0));
    // start below the base is raised to it
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 0));
    write_register(CfgDestCount, 13'h1fff);
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 13'h1fff));
    write_register(CfgDestCount, '0);
    send_request(make_request(MODE_OR, 0, MaxIds, 62, AllOnes, 0));
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 0));
    write_register(CfgDestBase, 13'hfff);
    write_register(CfgDestCount, 13'd1);
    send_request(make_request(MODE_OR, 0, MaxIds, 63, AllOnes, 0));
    send_request(make_request(MODE_FIND, 0, 0, 0, '0, 0));
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_full_stall();
    configure(0, MaxIds);
    hold_req = 1'b1;
    repeat (30) send_request(random_request());
  endtask

  task automatic test_random_phases();
    int unsigned b, c;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin b = 0; c = MaxIds; end
        1: begin b = MaxIds - 1; c = 1; end
        2: begin b = WordBits; c = 2 * WordBits; end
        3: begin b = 0; c = 1; end
        default: begin
          b = $urandom_range(0, MaxIds - 1);
          c = $urandom_range(0, MaxIds - b);
        end
      endcase
      configure(b, c);
      repeat (86) send_request(random_request());
    end
  endtask

  task automatic test_steady_tail();
    configure(17, MaxIds - 96);
    calm = 1'b1;
    repeat (100) send_request(random_request());
  endtask

  // Result port: random stalls, plus one long hold on request
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result(res_out);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (mask_mem[i]) mask_mem[i] = '0;
    dest_base  = 0;
    dest_count = (MaxIds < 4096) ? MaxIds : 4096;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_word_ops();
    test_find();
    test_zero_and_spare_modes();
    test_register_limits();
    test_full_stall();
    test_random_phases();
    test_steady_tail();

    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
